// ===== src/playfair_decipher_core_assert.svh =====
// assertion macros shared by the checker
`ifndef PLAYFAIR_DECIPHER_CORE_ASSERT_SVH
`define PLAYFAIR_DECIPHER_CORE_ASSERT_SVH

// checked property, held off while reset is asserted
`define PFD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked property that also covers the reset cycles
`define PFD_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pfd_pkg.sv =====
`default_nettype none

package pfd_pkg;

    localparam int SIDE    = 5;
    localparam int CELLS   = SIDE * SIDE;
    localparam int LETTERS = 26;
    localparam int LETTER_W = 5;
    localparam int CELL_W  = $clog2(CELLS);
    localparam int RC_W    = $clog2(SIDE);

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [CELL_W-1:0]   cell_t;
    typedef logic [RC_W-1:0]     rc_t;
    typedef logic [LETTERS-1:0]  used_t;

    localparam letter_t CODE_A = letter_t'(0);
    localparam letter_t CODE_I = letter_t'(8);
    localparam letter_t CODE_J = letter_t'(9);
    localparam letter_t CODE_LAST = letter_t'(LETTERS - 1);

    typedef enum logic [1:0] {
        MODE_KEY    = 2'd0,
        MODE_FINISH = 2'd1,
        MODE_PAIR   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_LOOKUP,
        ST_FETCH,
        ST_REPLY
    } state_t;

    typedef struct packed {
        logic [1:0] mode;
        letter_t    letter_a;
        letter_t    letter_b;
    } in_t;

    typedef struct packed {
        letter_t plain_a;
        letter_t plain_b;
        logic    status;
    } out_t;

    typedef struct packed {
        logic key_load;
        logic fill_start;
        logic fill_step;
        logic pair_start;
        logic lookup;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic complete;
        logic scan_last;
        logic out_free;
    } stat_t;

    typedef struct packed {
        rc_t row;
        rc_t col;
    } pos_t;

    function automatic pos_t split_cell(cell_t p);
        pos_t q;
        q.row = '0;
        for (int r = 1; r < SIDE; r++) begin
            if (p >= cell_t'(r * SIDE)) begin
                q.row = rc_t'(r);
            end
        end
        q.col = rc_t'(p - cell_t'(q.row) * cell_t'(SIDE));
        return q;
    endfunction

    function automatic cell_t join_cell(rc_t row, rc_t col);
        return cell_t'(cell_t'(row) * cell_t'(SIDE) + cell_t'(col));
    endfunction

    function automatic rc_t prev_rc(rc_t x);
        return (x == '0) ? rc_t'(SIDE - 1) : rc_t'(x - rc_t'(1));
    endfunction

endpackage

`default_nettype wire

// ===== src/pfd_ram.sv =====
`default_nettype none

module pfd_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 25
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ===== src/pfd_ctrl.sv =====
`default_nettype none

module pfd_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire logic [1:0]    mode,
    input  wire pfd_pkg::stat_t stat,
    output logic               s_ready,
    output pfd_pkg::cmd_t      cmd
);

    pfd_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            pfd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (mode)
                        pfd_pkg::MODE_KEY: begin
                            cmd.key_load = 1'b1;
                        end
                        pfd_pkg::MODE_FINISH: begin
                            if (!stat.complete) begin
                                cmd.fill_start = 1'b1;
                                state_next     = pfd_pkg::ST_FILL;
                            end
                        end
                        pfd_pkg::MODE_PAIR: begin
                            cmd.pair_start = 1'b1;
                            state_next = stat.complete ? pfd_pkg::ST_LOOKUP
                                                       : pfd_pkg::ST_REPLY;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pfd_pkg::ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = pfd_pkg::ST_IDLE;
                end
            end
            pfd_pkg::ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = pfd_pkg::ST_FETCH;
            end
            pfd_pkg::ST_FETCH: begin
                state_next = pfd_pkg::ST_REPLY;
            end
            pfd_pkg::ST_REPLY: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = pfd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/pfd_datapath.sv =====
`default_nettype none

module pfd_datapath (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire pfd_pkg::in_t   s_data,
    input  wire logic           m_ready,
    input  wire pfd_pkg::cmd_t  cmd,
    output pfd_pkg::stat_t      stat,
    output logic                m_valid,
    output pfd_pkg::out_t       m_data
);

    pfd_pkg::used_t   used_reg, used_next;
    pfd_pkg::cell_t   fill_reg, fill_next;
    logic             complete_reg, complete_next;
    pfd_pkg::letter_t scan_reg, scan_next;
    logic             nc_reg, a_big_reg, b_big_reg;
    pfd_pkg::cell_t   sqa_reg, sqb_reg;
    pfd_pkg::out_t    out_reg;
    logic             m_valid_reg, m_valid_next;

    pfd_pkg::used_t   eff_used;
    pfd_pkg::cell_t   eff_fill, base_fill;
    logic             key_ok, scan_ok, place, we;
    pfd_pkg::letter_t code;
    pfd_pkg::letter_t pos_raddr_a, pos_raddr_b;
    pfd_pkg::cell_t   pos_rd_a, pos_rd_b;
    pfd_pkg::letter_t sq_rd_a, sq_rd_b;
    pfd_pkg::cell_t   pa, pb, oa, ob;
    pfd_pkg::pos_t    qa, qb;

    function automatic pfd_pkg::letter_t map_letter(pfd_pkg::letter_t l);
        pfd_pkg::letter_t m;
        m = l;
        if (l == pfd_pkg::CODE_J) begin
            m = pfd_pkg::CODE_I;
        end else if (l > pfd_pkg::CODE_LAST) begin
            m = pfd_pkg::CODE_A;
        end
        return m;
    endfunction

    // square build
    always_comb begin
        eff_used  = complete_reg ? '0 : used_reg;
        eff_fill  = complete_reg ? '0 : fill_reg;
        key_ok    = (s_data.letter_a <= pfd_pkg::CODE_LAST)
                    && (s_data.letter_a != pfd_pkg::CODE_J)
                    && !eff_used[map_letter(s_data.letter_a)];
        scan_ok   = (scan_reg != pfd_pkg::CODE_J) && !used_reg[scan_reg];
        place     = (cmd.key_load && key_ok) || (cmd.fill_step && scan_ok);
        code      = cmd.fill_step ? scan_reg : s_data.letter_a;
        base_fill = cmd.key_load ? eff_fill : fill_reg;
        we        = place && (base_fill < pfd_pkg::cell_t'(pfd_pkg::CELLS));

        used_next     = used_reg;
        fill_next     = fill_reg;
        complete_next = complete_reg;
        scan_next     = scan_reg;
        if (cmd.key_load || cmd.fill_step) begin
            used_next = (cmd.key_load ? eff_used : used_reg)
                        | (place ? (pfd_pkg::used_t'(1) << code) : '0);
            fill_next = base_fill + pfd_pkg::cell_t'(we);
        end
        if (cmd.key_load) begin
            complete_next = 1'b0;
        end
        if (cmd.fill_step && stat.scan_last) begin
            complete_next = 1'b1;
        end
        if (cmd.fill_start) begin
            scan_next = pfd_pkg::CODE_A;
        end else if (cmd.fill_step) begin
            scan_next = scan_reg + pfd_pkg::letter_t'(1);
        end
    end

    // pair lookup
    always_comb begin
        pos_raddr_a = map_letter(s_data.letter_a);
        pos_raddr_b = map_letter(s_data.letter_b);
        pa = a_big_reg ? '0 : pos_rd_a;
        pb = b_big_reg ? '0 : pos_rd_b;
        qa = pfd_pkg::split_cell(pa);
        qb = pfd_pkg::split_cell(pb);
        if (qa.row == qb.row) begin
            oa = pfd_pkg::join_cell(qa.row, pfd_pkg::prev_rc(qa.col));
            ob = pfd_pkg::join_cell(qb.row, pfd_pkg::prev_rc(qb.col));
        end else if (qa.col == qb.col) begin
            oa = pfd_pkg::join_cell(pfd_pkg::prev_rc(qa.row), qa.col);
            ob = pfd_pkg::join_cell(pfd_pkg::prev_rc(qb.row), qb.col);
        end else begin
            oa = pfd_pkg::join_cell(qa.row, qb.col);
            ob = pfd_pkg::join_cell(qb.row, qa.col);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg     <= '0;
            fill_reg     <= '0;
            complete_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            used_reg     <= used_next;
            fill_reg     <= fill_next;
            complete_reg <= complete_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
        if (cmd.pair_start) begin
            nc_reg    <= !complete_reg;
            a_big_reg <= s_data.letter_a > pfd_pkg::CODE_LAST;
            b_big_reg <= s_data.letter_b > pfd_pkg::CODE_LAST;
        end
        if (cmd.lookup) begin
            sqa_reg <= oa;
            sqb_reg <= ob;
        end
        if (cmd.out_load) begin
            if (nc_reg) begin
                out_reg <= '{plain_a: '0, plain_b: '0, status: 1'b1};
            end else begin
                out_reg <= '{plain_a: sq_rd_a, plain_b: sq_rd_b, status: 1'b0};
            end
        end
    end

    // letter to cell
    pfd_ram #(
        .WIDTH (pfd_pkg::CELL_W),
        .DEPTH (pfd_pkg::LETTERS)
    ) u_pos_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (code),
        .wdata   (base_fill),
        .raddr_a (pos_raddr_a),
        .raddr_b (pos_raddr_b),
        .rdata_a (pos_rd_a),
        .rdata_b (pos_rd_b)
    );

    // cell to letter
    pfd_ram #(
        .WIDTH (pfd_pkg::LETTER_W),
        .DEPTH (pfd_pkg::CELLS)
    ) u_square_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (base_fill),
        .wdata   (code),
        .raddr_a (sqa_reg),
        .raddr_b (sqb_reg),
        .rdata_a (sq_rd_a),
        .rdata_b (sq_rd_b)
    );

    assign stat.complete  = complete_reg;
    assign stat.scan_last = (scan_reg == pfd_pkg::CODE_LAST);
    assign stat.out_free  = !m_valid_reg || m_ready;
    assign m_valid        = m_valid_reg;
    assign m_data         = out_reg;

endmodule

`default_nettype wire

// ===== src/playfair_decipher_core.sv =====
// Playfair decipher with a 5x5 letter square (A=0..Z=25, J shares the cell of I).
// A key letter beat leaves the core idle and ready. A finish beat on an unfinished
// square scans the alphabet once, one letter a cycle, and the core is busy until
// the scan ends; a finish beat on a finished square does nothing. A pair beat
// goes through two registered-read lookups in turn, first a letter-to-cell table
// and then the square itself, and its result is loaded into the output register
// in the reply state once that register is free (no result held, or m_ready
// high); the next beat is taken after that load. A pair sent before the square
// is finished skips the lookups, goes straight to the reply state and returns
// status 1 with zero letters. Both tables are small two-read-port RAMs written as
// each letter is placed; there is no clearing pass after reset. Only pair beats
// produce a result beat.
`default_nettype none

module playfair_decipher_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire pfd_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output pfd_pkg::out_t      m_data
);

    pfd_pkg::cmd_t  cmd;
    pfd_pkg::stat_t stat;

    pfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .mode    (s_data.mode),
        .stat    (stat),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    pfd_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== src/pfd_checker.sv =====
`default_nettype none
`include "playfair_decipher_core_assert.svh"

module pfd_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire pfd_pkg::in_t  s_data,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire pfd_pkg::out_t m_data
);

    `PFD_ASSERT_NR(a_reset_quiet, aclk, !aresetn |=> !m_valid,
        "result beat right after reset")

    `PFD_ASSERT(a_out_hold, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_data),
        "stalled result beat changed")

    `PFD_ASSERT(a_incomplete_zero, aclk, aresetn,
        m_valid && m_data.status |-> m_data.plain_a == 5'd0 && m_data.plain_b == 5'd0,
        "incomplete status with nonzero letters")

    `PFD_ASSERT(a_plain_legal, aclk, aresetn,
        m_valid && !m_data.status |->
            m_data.plain_a != pfd_pkg::CODE_J && m_data.plain_b != pfd_pkg::CODE_J
            && m_data.plain_a <= pfd_pkg::CODE_LAST && m_data.plain_b <= pfd_pkg::CODE_LAST,
        "deciphered letter outside the square")

endmodule

bind playfair_decipher_core pfd_checker u_checker (.*);

`default_nettype wire

// ===== bench/playfair_decipher_checker.sv =====
module playfair_decipher_checker
    import pfd_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    input  wire logic  s_ready,
    input  wire in_t   s_data,
    input  wire logic  m_valid,
    input  wire logic  m_ready,
    input  wire out_t  m_data,
    output int         queued_plain,
    output int         mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    letter_t     square_cells [CELLS];
    used_t       placed;
    int unsigned filled;
    bit          finished;
    out_t        plain_pending [$];
    out_t        want;

    function automatic void take_letter(letter_t code);
        if (filled < CELLS) begin
            square_cells[filled] = code;
            filled++;
        end
        placed[code] = 1'b1;
    endfunction

    // j shares the cell of i
    function automatic int unsigned cell_of(letter_t code);
        letter_t c;
        c = (code == CODE_J) ? CODE_I : code;
        for (int k = 0; k < CELLS; k++) begin
            if (square_cells[k] == c) begin
                return k;
            end
        end
        return 0;
    endfunction

    function automatic void decipher_beat(in_t beat);
        int unsigned pa, pb, ra, ca, rb, cb, oa, ob;
        out_t plain;
        plain = '0;
        case (beat.mode)
            MODE_KEY: begin
                if (finished) begin
                    placed = '0;
                    filled = 0;
                    finished = 1'b0;
                end
                if (beat.letter_a < LETTERS && beat.letter_a != CODE_J
                        && !placed[beat.letter_a]) begin
                    take_letter(beat.letter_a);
                end
            end
            MODE_FINISH: begin
                if (!finished) begin
                    for (int c = 0; c < LETTERS; c++) begin
                        if (letter_t'(c) != CODE_J && !placed[c]) begin
                            take_letter(letter_t'(c));
                        end
                    end
                    finished = 1'b1;
                end
            end
            MODE_PAIR: begin
                if (!finished) begin
                    plain.status = 1'b1;
                end else begin
                    // codes past z sit at the top left cell
                    pa = (beat.letter_a < LETTERS) ? cell_of(beat.letter_a) : 0;
                    pb = (beat.letter_b < LETTERS) ? cell_of(beat.letter_b) : 0;
                    ra = pa / SIDE;
                    ca = pa % SIDE;
                    rb = pb / SIDE;
                    cb = pb % SIDE;
                    if (ra == rb) begin
                        oa = ra * SIDE + (ca + SIDE - 1) % SIDE;
                        ob = rb * SIDE + (cb + SIDE - 1) % SIDE;
                    end else if (ca == cb) begin
                        oa = ((ra + SIDE - 1) % SIDE) * SIDE + ca;
                        ob = ((rb + SIDE - 1) % SIDE) * SIDE + cb;
                    end else begin
                        oa = ra * SIDE + cb;
                        ob = rb * SIDE + ca;
                    end
                    plain.plain_a = square_cells[oa];
                    plain.plain_b = square_cells[ob];
                end
                plain_pending.push_back(plain);
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            placed = '0;
            filled = 0;
            finished = 1'b0;
            plain_pending.delete();
            queued_plain <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (plain_pending.size() == 0) begin
                    $error("result beat with no deciphered pair pending");
                    mismatches++;
                end else begin
                    want = plain_pending.pop_front();
                    if (m_data.plain_a !== want.plain_a) begin
                        $error("plain_a expected %0d got %0d", want.plain_a, m_data.plain_a);
                        mismatches++;
                    end
                    if (m_data.plain_b !== want.plain_b) begin
                        $error("plain_b expected %0d got %0d", want.plain_b, m_data.plain_b);
                        mismatches++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, m_data.status);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                decipher_beat(s_data);
            end
            queued_plain <= plain_pending.size();
        end
    end

endmodule

// ===== bench/playfair_decipher_core_tb.sv =====
module playfair_decipher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pfd_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int BEATS_PER_PHASE = 400;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    int queued_plain;
    int mismatches;
    int idle_pct = 0;
    int stall_pct = 0;
    int sent_beats = 0;
    int quiet_cycles = 0;

    playfair_decipher_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    playfair_decipher_checker u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .queued_plain (queued_plain),
        .mismatches   (mismatches)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("playfair_decipher_core_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic in_t make_beat(logic [1:0] mode, letter_t a, letter_t b);
        in_t beat;
        beat.mode = mode;
        beat.letter_a = a;
        beat.letter_b = b;
        return beat;
    endfunction

    // mostly real letters, now and then a code past z
    function automatic letter_t any_letter();
        if ($urandom_range(99) < 8) begin
            return letter_t'($urandom_range(31, LETTERS));
        end
        return letter_t'($urandom_range(LETTERS - 1));
    endfunction

    function automatic letter_t any_code();
        return letter_t'($urandom_range(31));
    endfunction

    task automatic send_beat(in_t beat);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= beat;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if (beat.mode != MODE_UNUSED) begin
            sent_beats++;
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (queued_plain != 0);
    endtask

    task automatic random_session();
        int key_len;
        int pair_cnt;
        key_len = $urandom_range(12);
        pair_cnt = $urandom_range(16, 1);
        for (int k = 0; k < key_len; k++) begin
            send_beat(make_beat(MODE_KEY, any_letter(), any_code()));
        end
        if ($urandom_range(9) == 0) begin
            send_beat(make_beat(MODE_PAIR, any_letter(), any_letter()));
        end
        send_beat(make_beat(MODE_FINISH, any_code(), any_code()));
        if ($urandom_range(19) == 0) begin
            send_beat(make_beat(MODE_FINISH, any_code(), any_code()));
        end
        for (int p = 0; p < pair_cnt; p++) begin
            send_beat(make_beat(MODE_PAIR, any_letter(), any_letter()));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // pair before the square exists, then the plain alphabet square
        send_beat(make_beat(MODE_PAIR, CODE_A, CODE_LAST));
        send_beat(make_beat(MODE_KEY, 5'd31, 5'd31));
        send_beat(make_beat(MODE_FINISH, CODE_A, CODE_A));
        send_beat(make_beat(MODE_FINISH, 5'd31, 5'd31));
        send_beat(make_beat(MODE_PAIR, CODE_A, 5'd2));
        send_beat(make_beat(MODE_PAIR, CODE_A, 5'd5));
        send_beat(make_beat(MODE_PAIR, CODE_A, CODE_LAST));
        send_beat(make_beat(MODE_PAIR, CODE_J, 5'd10));
        send_beat(make_beat(MODE_PAIR, 5'd26, 5'd31));
        send_beat(make_beat(MODE_PAIR, CODE_LAST, 5'd31));
        send_beat(make_beat(MODE_PAIR, CODE_LAST, CODE_LAST));
        send_beat(make_beat(MODE_UNUSED, 5'd31, 5'd31));
        // new keyword square over a finished one
        send_beat(make_beat(MODE_KEY, CODE_LAST, CODE_A));
        send_beat(make_beat(MODE_KEY, CODE_J, CODE_A));
        send_beat(make_beat(MODE_KEY, CODE_LAST, CODE_A));
        send_beat(make_beat(MODE_KEY, CODE_A, CODE_A));
        send_beat(make_beat(MODE_KEY, 5'd31, CODE_A));
        send_beat(make_beat(MODE_PAIR, CODE_I, CODE_J));
        send_beat(make_beat(MODE_FINISH, CODE_A, CODE_A));
        send_beat(make_beat(MODE_PAIR, CODE_J, CODE_I));
        send_beat(make_beat(MODE_PAIR, 5'd1, 5'd24));
        send_beat(make_beat(MODE_PAIR, 5'd31, CODE_A));
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct = 56;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct <= 56;
                end
                default: begin
                    idle_pct = 10;
                    stall_pct <= 10;
                end
            endcase
            while (sent_beats < (ph + 1) * BEATS_PER_PHASE) begin
                if ($urandom_range(9) == 0) begin
                    send_beat(make_beat(logic'(0) ? MODE_KEY : 2'($urandom_range(3)),
                                        any_code(), any_code()));
                end else begin
                    random_session();
                end
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && queued_plain == 0) begin
            $display("playfair_decipher_core_tb OK");
        end else begin
            $display("playfair_decipher_core_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/pfd_pkg.sv
src/pfd_ram.sv
src/pfd_ctrl.sv
src/pfd_datapath.sv
src/playfair_decipher_core.sv
src/pfd_checker.sv
bench/playfair_decipher_checker.sv
bench/playfair_decipher_core_tb.sv
